// ===== hw/rtl/hamming_sec_codec_defines.svh =====
// Assertion macros for the Hamming codec top level.
`ifndef HAMMING_SEC_CODEC_DEFINES_SVH
`define HAMMING_SEC_CODEC_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge outside reset.
`define HSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("hamming_sec_codec: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define HSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("hamming_sec_codec: next-cycle check failed");

`else

`define HSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define HSC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/hsc_pkg.sv =====
// Package of constants, codes and helper functions for the Hamming codec.
package hsc_pkg;

	// Field widths and limits.
	localparam int MAX_DATA_BITS = 57;
	localparam int DATA_W        = 57;
	localparam int CODE_W        = 63;
	localparam int SYN_W         = 6;
	localparam int CHK_W         = 3;
	localparam int K_W           = 6;

	// Item kinds.
	localparam logic KIND_ENCODE = 1'b0;
	localparam logic KIND_DECODE = 1'b1;

	// Result classification.
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_PARITY = 2'd1,
		ST_FIXED  = 2'd2,
		ST_RANGE  = 2'd3
	} status_t;

	// Positions q (1-based) whose index has bit t set, as a mask.
	function automatic logic [CODE_W-1:0] cover_mask(input int t);
		logic [CODE_W-1:0] m;
		m = '0;
		for (int q = 1; q <= CODE_W; q++) begin
			m[q-1] = ((q >> t) & 1) != 0;
		end
		return m;
	endfunction

	// Index of the data slot at a non-power-of-two position q.
	function automatic int data_index(input int q);
		return q - 1 - $clog2(q + 1);
	endfunction

	// Least number of check bits that covers k data bits.
	function automatic logic [CHK_W-1:0] check_count(input logic [K_W-1:0] k);
		logic [CHK_W-1:0] r;
		if (k <= 6'd1) begin
			r = 3'd2;
		end else if (k <= 6'd4) begin
			r = 3'd3;
		end else if (k <= 6'd11) begin
			r = 3'd4;
		end else if (k <= 6'd26) begin
			r = 3'd5;
		end else begin
			r = 3'd6;
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/hsc_parity.sv =====
// Syndrome parity trees over one 63-bit codeword.
module hsc_parity import hsc_pkg::*; (
	input  logic [CODE_W-1:0] word,
	output logic [SYN_W-1:0]  syn
);

	// Each syndrome bit is the even parity of the positions it covers.
	always_comb begin
		for (int t = 0; t < SYN_W; t++) begin
			syn[t] = ^(word & cover_mask(t));
		end
	end

endmodule

// ===== hw/rtl/hamming_sec_codec.sv =====
// Top level of the pipelined Hamming single-error-correcting codec.
//
// Input channel (in_valid / in_stall): one beat carries kind, data_word and
// received_word. Kind 0 encodes data_word; kind 1 checks and corrects
// received_word. Output channel (out_valid / out_stall): one beat carries
// code_word, check_bits, syndrome and status for each input beat, in order.
// Configuration channel (cfg_valid / cfg_ready): cfg_data sets the number of
// data bits in use; cfg_ready is always high. Write it only while idle.
// One beat is taken every cycle while in_stall is low: stage one places
// data bits or masks the received word, stage two runs the syndrome parity
// trees, stage three classifies, corrects and holds the result.
// Reset empties the pipeline and sets the data bit count to four.
// When the receiver stalls, the pipeline fills its empty stages and then
// raises in_stall; no beat is lost or repeated.
`include "hamming_sec_codec_defines.svh"

module hamming_sec_codec import hsc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [K_W-1:0]    cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              kind,
	input  logic [DATA_W-1:0] data_word,
	input  logic [CODE_W-1:0] received_word,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CODE_W-1:0] code_word,
	output logic [CHK_W-1:0]  check_bits,
	output logic [SYN_W-1:0]  syndrome,
	output logic [1:0]        status
);

	logic [K_W-1:0]    data_bits_q;
	logic [K_W-1:0]    k_eff;
	logic [CHK_W-1:0]  r_eff;
	logic [K_W-1:0]    n_eff;
	logic [CODE_W-1:0] n_mask;

	logic              adv_s1, adv_s2, adv_s3;
	logic              valid_s1, valid_s2, valid_s3;
	logic              kind_s1, kind_s2;
	logic [CODE_W-1:0] word_s1, word_s2;
	logic [SYN_W-1:0]  syn_s2;

	logic [DATA_W-1:0] rev_src;
	logic [DATA_W-1:0] rev;
	logic [K_W-1:0]    shamt;
	logic [CODE_W-1:0] placed;
	logic [SYN_W-1:0]  syn_c;

	logic [CODE_W-1:0] code_c;
	logic [SYN_W-1:0]  syn_out_c;
	status_t           status_c;

	logic [CODE_W-1:0] code_word_s3;
	logic [CHK_W-1:0]  check_bits_s3;
	logic [SYN_W-1:0]  syndrome_s3;
	status_t           status_s3;

	// Configuration register; every write is taken at once.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_bits_q <= 6'd4;
		end else if (cfg_valid && cfg_ready) begin
			data_bits_q <= cfg_data;
		end
	end

	// Effective data bit count, check bit count and codeword length.
	always_comb begin
		if (data_bits_q == '0) begin
			k_eff = 6'd1;
		end else if (data_bits_q > K_W'(MAX_DATA_BITS)) begin
			k_eff = K_W'(MAX_DATA_BITS);
		end else begin
			k_eff = data_bits_q;
		end
		r_eff  = check_count(k_eff);
		n_eff  = k_eff + {{(K_W-CHK_W){1'b0}}, r_eff};
		n_mask = ~({CODE_W{1'b1}} << n_eff);
	end

	// Pipeline flow: a stage moves on when it is empty or the next one moves.
	assign adv_s3   = !valid_s3 || !out_stall;
	assign adv_s2   = !valid_s2 || adv_s3;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= in_valid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
		end
	end

	// Stage one: data bits k..1 go to positions 3, 5, 6, 7, ... in turn.
	// Reversing the word and shifting by the unused width does this.
	always_comb begin
		for (int j = 0; j < DATA_W; j++) begin
			rev_src[j] = data_word[DATA_W-1-j];
		end
		shamt = K_W'(DATA_W) - k_eff;
		rev   = rev_src >> shamt;
	end

	for (genvar q = 1; q <= CODE_W; q++) begin : g_place
		if ((q & (q - 1)) == 0) begin : g_check
			assign placed[q-1] = 1'b0;
		end else begin : g_data
			localparam int IDX = data_index(q);
			assign placed[q-1] = rev[IDX];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			kind_s1 <= kind;
			word_s1 <= (kind == KIND_ENCODE) ? placed : (received_word & n_mask);
		end
	end

	// Stage two: syndrome over the placed or received word.
	hsc_parity u_parity (
		.word (word_s1),
		.syn  (syn_c)
	);

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			kind_s2 <= kind_s1;
			word_s2 <= word_s1;
			syn_s2  <= syn_c;
		end
	end

	// Stage three: insert check bits, or classify and correct.
	always_comb begin
		code_c    = word_s2;
		syn_out_c = '0;
		status_c  = ST_OK;
		if (kind_s2 == KIND_ENCODE) begin
			for (int t = 0; t < SYN_W; t++) begin
				code_c[(1 << t) - 1] = syn_s2[t];
			end
		end else begin
			syn_out_c = syn_s2;
			if (syn_s2 == '0) begin
				status_c = ST_OK;
			end else if ((syn_s2 & (syn_s2 - 6'd1)) == '0) begin
				status_c = ST_PARITY;
			end else if (syn_s2 <= n_eff) begin
				code_c   = word_s2 ^ (CODE_W'(1) << (syn_s2 - 6'd1));
				status_c = ST_FIXED;
			end else begin
				status_c = ST_RANGE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && valid_s2) begin
			code_word_s3  <= code_c;
			check_bits_s3 <= r_eff;
			syndrome_s3   <= syn_out_c;
			status_s3     <= status_c;
		end
	end

	assign out_valid  = valid_s3;
	assign code_word  = code_word_s3;
	assign check_bits = check_bits_s3;
	assign syndrome   = syndrome_s3;
	assign status     = status_s3;

	// Checks on the pipeline and the classification.
	`HSC_ASSERT_IMPLY(a_stall_full, clk, arst_n, in_stall, valid_s1 && valid_s2 && valid_s3)
	`HSC_ASSERT_NEXT(a_hold_result, clk, arst_n, valid_s3 && out_stall, valid_s3)
	`HSC_ASSERT_IMPLY(a_zero_syn_ok, clk, arst_n, out_valid && syndrome == '0, status == ST_OK)
	`HSC_ASSERT_IMPLY(a_parity_onehot, clk, arst_n, out_valid && status == ST_PARITY, $onehot(syndrome))
	`HSC_ASSERT_IMPLY(a_upper_zero, clk, arst_n, out_valid, (code_word & ~n_mask) == '0)

endmodule
